// File: hw/rtl/wmop_pkg.sv
package wmop_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int MaxRadiusDef = 31;
  localparam int CompBits     = 8;
  localparam int Levels       = 1 << CompBits;

  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_RADIUS        = 2'd2;
  localparam logic [1:0] CFG_USE_INTENSITY = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [7:0] LumaR = 8'd77;
  localparam logic [7:0] LumaG = 8'd150;
  localparam logic [7:0] LumaB = 8'd29;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [7:0] out_x;
    logic [7:0] out_y;
  } out_item_t;

  typedef logic [31:0] pixel_t;

endpackage

// File: hw/rtl/wmop_hist.sv
// Four 256-bin histograms in one memory, read-modify-write with forwarding.
// A bin count of a window never exceeds 31*31, so 12 bits suffice.
module wmop_hist #(
  parameter int CntBits = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr_en,
  input  logic [7:0]          clr_addr,
  input  logic                upd_en,
  input  logic [3:0][7:0]     upd_bin,
  output logic                res_en,
  output logic [3:0][CntBits-1:0] res_cnt
);
  import wmop_pkg::*;

  logic [3:0][CntBits-1:0] rd_r;
  logic [3:0][7:0] bin_r;
  logic            upd_r;
  logic [3:0][CntBits-1:0] wr_cnt;
  logic [3:0][CntBits-1:0] fwd;

  // The read address differs per lane, so each lane has its own row of the
  // memory.
  logic [CntBits-1:0] lane_mem [4][Levels];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      rd_r[k] <= lane_mem[k][upd_bin[k]];
      if (clr_en) begin
        lane_mem[k][clr_addr] <= '0;
      end else if (upd_r) begin
        lane_mem[k][bin_r[k]] <= wr_cnt[k];
      end
    end
    bin_r <= upd_bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
    end else begin
      upd_r <= upd_en;
    end
  end

  // A back-to-back update of the same bin takes the count being written.
  logic [3:0] hit_r;
  logic [3:0][CntBits-1:0] wr_prev_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      hit_r[k]     <= upd_r && upd_en && (bin_r[k] == upd_bin[k]);
      wr_prev_r[k] <= wr_cnt[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fwd[k]    = hit_r[k] ? wr_prev_r[k] : rd_r[k];
      wr_cnt[k] = fwd[k] + CntBits'(1);
    end
  end

  assign res_en  = upd_r;
  assign res_cnt = wr_cnt;

  hist_no_clear_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_en && upd_en)) else $error("histogram clear overlaps update");
  hist_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> res_en) else $error("histogram result missing");
  hist_fwd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_r && upd_en && bin_r[0] == upd_bin[0]) |=> res_cnt[0] == $past(res_cnt[0]) + 1'b1)
    else $error("histogram forwarding broken");
endmodule

// File: hw/rtl/windowed_mode_oil_paint_filter_unit.sv
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | wmop_pkg::in_item_t
// out     | output    | out_valid/stall | wmop_pkg::out_item_t
// cfg     | input     | cfg_valid/ready | cfg_index, cfg_data
// A load is written at its transfer edge; the next transfer can be taken in the cycle after.
// A compute holds the input while the histograms are cleared (one bin of each
// histogram per cycle) and the window is scanned, then while the pipeline drains,
// and then offers the result; an empty window skips the scan. The one frame store
// read per cycle and the histogram read-modify-write loop set one pixel per cycle.
// Reset is synchronous, active low; the frame store is not cleared.
// The result sits in an output register; a stall holds it and the block.
module windowed_mode_oil_paint_filter_unit #(
  parameter int MAX_RADIUS = wmop_pkg::MaxRadiusDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wmop_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wmop_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data
);
  import wmop_pkg::*;

  localparam int MAX_WIDTH  = MaxWidthDef;
  localparam int MAX_HEIGHT = MaxHeightDef;
  localparam int XBits = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int YBits = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int CBits = 14;
  localparam int CntBits = 2 * $clog2(MAX_RADIUS + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DRN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [8:0] fw_r, fh_r;
  logic [4:0] rad_r;
  logic       intens_r;
  logic [2:0] st_r, st_nxt;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 9'd256; fh_r <= 9'd256; rad_r <= 5'd7; intens_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   fw_r <= cfg_data;
        CFG_FRAME_HEIGHT:  fh_r <= cfg_data;
        CFG_RADIUS:        rad_r <= cfg_data[4:0];
        CFG_USE_INTENSITY: intens_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Window bounds in signed 14-bit arithmetic.
  logic signed [CBits-1:0] wc, hc, nc, bx0, bx1, by0, by1;
  always_comb begin
    wc = (CBits'(fw_r) > CBits'(MAX_WIDTH)) ? CBits'(MAX_WIDTH) : CBits'(fw_r);
    hc = (CBits'(fh_r) > CBits'(MAX_HEIGHT)) ? CBits'(MAX_HEIGHT) : CBits'(fh_r);
    nc = ((CBits'(rad_r) > CBits'(MAX_RADIUS)) ? CBits'(MAX_RADIUS) : CBits'(rad_r)) >>> 1;
    bx0 = CBits'(in_data.pos_x) - nc;
    bx1 = CBits'(in_data.pos_x) + nc + CBits'(1);
    by0 = CBits'(in_data.pos_y) - nc;
    by1 = CBits'(in_data.pos_y) + nc + CBits'(1);
    bx0 = bx0 < 0 ? '0 : (bx0 > wc ? wc : bx0);
    bx1 = bx1 < 0 ? '0 : (bx1 > wc ? wc : bx1);
    by0 = by0 < 0 ? '0 : (by0 > hc ? hc : by0);
    by1 = by1 < 0 ? '0 : (by1 > hc ? hc : by1);
  end

  logic [CBits-1:0] x0_r, x1_r, y1_r, xx_r, yy_r;
  logic [7:0] px_r, py_r, clr_r;
  logic       mode_r;

  // Frame store: one read per cycle, and a write for each accepted load.
  pixel_t frame_mem [MAX_WIDTH * MAX_HEIGHT];
  pixel_t pix_rd_r;
  logic   rd_v_r;
  logic   accept, do_load, rd_en;
  logic [XBits+YBits-1:0] rd_addr;

  logic res_en;
  logic [3:0][CntBits-1:0] res_cnt;

  assign in_stall = (st_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign do_load  = accept && in_data.cmd == CMD_LOAD &&
                    32'(in_data.pos_x) < MAX_WIDTH && 32'(in_data.pos_y) < MAX_HEIGHT;
  assign rd_en    = (st_r == S_SCAN);
  assign rd_addr  = {yy_r[YBits-1:0], xx_r[XBits-1:0]};

  always_ff @(posedge clk) begin
    if (do_load) begin
      frame_mem[{in_data.pos_y[YBits-1:0], in_data.pos_x[XBits-1:0]}] <=
        {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};
    end
    pix_rd_r <= frame_mem[rd_addr];
  end

  logic scan_last, empty_win;
  assign scan_last = (xx_r + 1'b1 >= x1_r) && (yy_r + 1'b1 >= y1_r);
  assign empty_win = (bx0 >= bx1) || (by0 >= by1);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (accept && in_data.cmd == CMD_COMPUTE) st_nxt = S_CLR;
      S_CLR:  if (clr_r == 8'hff) st_nxt = (x0_r >= x1_r) ? S_OUT : S_SCAN;
      S_SCAN: if (scan_last) st_nxt = S_DRN;
      S_DRN:  if (!rd_v_r && !res_en) st_nxt = S_OUT;
      S_OUT:  if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  pixel_t pix2_r;
  logic [3:0][7:0] bin;
  logic [15:0] luma;
  logic [3:0][CntBits-1:0] max_r;
  logic [3:0][7:0] best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rd_v_r <= 1'b0; clr_r <= '0;
    end else begin
      st_r   <= st_nxt;
      rd_v_r <= rd_en;
      clr_r  <= (st_r == S_CLR) ? clr_r + 8'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_data.pos_x; py_r <= in_data.pos_y; mode_r <= intens_r;
      x0_r <= empty_win ? '0 : bx0; x1_r <= empty_win ? '0 : bx1;
      y1_r <= by1; xx_r <= bx0; yy_r <= by0;
    end else if (rd_en) begin
      if (xx_r + 1'b1 >= x1_r) begin
        xx_r <= x0_r; yy_r <= yy_r + 1'b1;
      end else begin
        xx_r <= xx_r + 1'b1;
      end
    end
    pix2_r <= pix_rd_r;
  end

  always_comb begin
    luma = 16'(pix_rd_r[7:0]) * 16'(LumaR) + 16'(pix_rd_r[15:8]) * 16'(LumaG) +
           16'(pix_rd_r[23:16]) * 16'(LumaB);
    bin[0] = mode_r ? luma[15:8] : pix_rd_r[7:0];
    bin[1] = pix_rd_r[15:8];
    bin[2] = pix_rd_r[23:16];
    bin[3] = pix_rd_r[31:24];
  end

  wmop_hist #(.CntBits(CntBits)) u_hist (
    .clk(clk), .rst_n(rst_n),
    .clr_en(st_r == S_CLR), .clr_addr(clr_r),
    .upd_en(rd_v_r), .upd_bin(bin),
    .res_en(res_en), .res_cnt(res_cnt)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_CLR) begin
      max_r <= '0; best_r <= '0;
    end else if (res_en) begin
      if (mode_r) begin
        if (res_cnt[0] > max_r[0]) begin
          max_r[0] <= res_cnt[0];
          best_r <= {pix2_r[31:24], pix2_r[23:16], pix2_r[15:8], pix2_r[7:0]};
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (res_cnt[k] > max_r[k]) begin
            max_r[k] <= res_cnt[k]; best_r[k] <= pix2_r[8*k +: 8];
          end
        end
      end
    end
  end

  assign out_valid = (st_r == S_OUT);
  always_comb begin
    out_data = '{out_red: best_r[0], out_green: best_r[1], out_blue: best_r[2],
                 out_alpha: best_r[3], out_x: px_r, out_y: py_r};
  end

  top_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  top_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> st_r == S_SCAN && !do_load) else $error("read during load");
  top_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == S_DRN || $past(st_r) == S_CLR)
    else $error("result without scan");
endmodule
